// File: design/mskds_pkg.sv
`default_nettype none

package mskds_pkg;

    localparam int SUM_W  = 64;
    localparam int CFG_W  = 5;
    localparam int QDEPTH = 2;

    typedef logic signed [SUM_W-1:0] sum_t;

    typedef struct packed {
        sum_t x;
        logic last;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } q_out_t;

endpackage

`default_nettype wire

// File: design/max_sum_k_disjoint_subarrays.sv
// A final beat passes the input queue and the run-count cells before its result is registered.
// Throughput: one beat per cycle while in_stall is low; all K_MAX run-count cells update together.
// A final beat waits only while the output register is full and stalled.
// Reset (async, active low): all run state invalid, running best cleared, k = 1.
// After each result, run state returns to the reset state; k is kept.
`default_nettype none

module max_sum_k_disjoint_subarrays #(
    parameter int K_MAX       = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic signed [VALUE_WIDTH-1:0]       value,
    input  wire logic                                last,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic signed [mskds_pkg::SUM_W-1:0]       max_sum,
    output logic                                     found,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [mskds_pkg::CFG_W-1:0]         segment_count
);
    import mskds_pkg::*;

    localparam int KW = (K_MAX > 1) ? $clog2(K_MAX) : 1;

    logic [KW-1:0] seg_idx_reg;
    logic [KW-1:0] seg_idx_next;
    q_out_t        q;
    logic          pop;
    sum_t          sel_sum;
    logic          sel_valid;
    sum_t          max_sum_w;

    assign cfg_ready = 1'b1;

    // clamp k into 1..K_MAX and keep it as a cell index
    always_comb
    begin
        seg_idx_next = seg_idx_reg;
        if (cfg_valid && cfg_ready)
        begin
            if (segment_count == '0)
            begin
                seg_idx_next = '0;
            end
            else if (int'(segment_count) > K_MAX)
            begin
                seg_idx_next = KW'(K_MAX - 1);
            end
            else
            begin
                seg_idx_next = KW'(segment_count - 1'b1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_idx_reg <= '0;
        end
        else
        begin
            seg_idx_reg <= seg_idx_next;
        end
    end

    mskds_front #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .value    (value),
        .last     (last),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .pop      (pop),
        .q        (q)
    );

    mskds_cells #(
        .K_MAX(K_MAX),
        .KW   (KW)
    ) u_cells (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (pop),
        .item      (q.item),
        .sel_idx   (seg_idx_reg),
        .sel_sum   (sel_sum),
        .sel_valid (sel_valid)
    );

    mskds_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q         (q),
        .pop       (pop),
        .sel_sum   (sel_sum),
        .sel_valid (sel_valid),
        .max_sum   (max_sum_w),
        .found     (found),
        .out_valid (out_valid),
        .out_stall (out_stall)
    );

    assign max_sum = max_sum_w;

endmodule

`default_nettype wire

// File: design/mskds_front.sv
`default_nettype none

module mskds_front #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic signed [VALUE_WIDTH-1:0] value,
    input  wire logic                          last,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          pop,
    output mskds_pkg::q_out_t                  q
);
    import mskds_pkg::*;

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);

    logic [VALUE_WIDTH-1:0] val_mem [QDEPTH];
    logic                   last_mem [QDEPTH];
    logic [PW-1:0]          wr_ptr_reg;
    logic [PW-1:0]          wr_ptr_next;
    logic [PW-1:0]          rd_ptr_reg;
    logic [PW-1:0]          rd_ptr_next;
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;
    logic                   push;
    logic [VALUE_WIDTH-1:0] head;

    assign in_stall = (count_reg == CW'(QDEPTH));
    assign push     = in_valid && !in_stall;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            val_mem[wr_ptr_reg]  <= value;
            last_mem[wr_ptr_reg] <= last;
        end
    end

    // sign-extend the head beat to the sum width
    assign head        = val_mem[rd_ptr_reg];
    assign q.valid     = (count_reg != '0);
    assign q.item.x    = {{(SUM_W - VALUE_WIDTH){head[VALUE_WIDTH-1]}}, head};
    assign q.item.last = last_mem[rd_ptr_reg];

endmodule

`default_nettype wire

// File: design/mskds_cells.sv
`default_nettype none

module mskds_cells #(
    parameter int K_MAX = 16,
    parameter int KW    = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire mskds_pkg::item_t item,
    input  wire logic [KW-1:0]    sel_idx,
    output mskds_pkg::sum_t       sel_sum,
    output logic                  sel_valid
);
    import mskds_pkg::*;

    function automatic sum_t sat_add(input sum_t a, input sum_t b);
        logic [SUM_W:0] s;
        sum_t           r;
        begin
            s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
            if (s[SUM_W] != s[SUM_W-1])
            begin
                r = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
            end
            else
            begin
                r = s[SUM_W-1:0];
            end
            return r;
        end
    endfunction

    sum_t end_reg   [K_MAX];
    sum_t end_next  [K_MAX];
    logic end_v_reg [K_MAX];
    logic end_v_next[K_MAX];
    sum_t few_reg   [K_MAX];
    sum_t few_next  [K_MAX];
    logic few_v_reg [K_MAX];
    logic few_v_next[K_MAX];
    logic start_reg;

    logic pe_v  [K_MAX];
    logic pf_v  [K_MAX];
    sum_t fewer [K_MAX];
    logic fewer_v[K_MAX];
    sum_t base  [K_MAX];
    logic base_v[K_MAX];

    // first beat after a sequence end sees the cleared state
    always_comb
    begin
        for (int j = 0; j < K_MAX; j++)
        begin
            pe_v[j] = end_v_reg[j] && !start_reg;
            pf_v[j] = few_v_reg[j] && !start_reg;
        end

        fewer[0]   = '0;
        fewer_v[0] = 1'b1;
        for (int j = 1; j < K_MAX; j++)
        begin
            fewer[j]   = few_reg[j];
            fewer_v[j] = pf_v[j];
            if (pe_v[j-1] && (!pf_v[j] || end_reg[j-1] > few_reg[j]))
            begin
                fewer[j]   = end_reg[j-1];
                fewer_v[j] = 1'b1;
            end
        end

        for (int j = 0; j < K_MAX; j++)
        begin
            base[j]   = fewer[j];
            base_v[j] = fewer_v[j];
            if (pe_v[j] && (!fewer_v[j] || end_reg[j] > fewer[j]))
            begin
                base[j]   = end_reg[j];
                base_v[j] = 1'b1;
            end
            few_next[j]   = fewer_v[j] ? fewer[j] : '0;
            few_v_next[j] = fewer_v[j];
            end_next[j]   = base_v[j] ? sat_add(base[j], item.x) : '0;
            end_v_next[j] = base_v[j];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= 1'b1;
            for (int j = 0; j < K_MAX; j++)
            begin
                end_v_reg[j] <= 1'b0;
                few_v_reg[j] <= 1'b0;
            end
        end
        else if (step)
        begin
            start_reg <= item.last;
            for (int j = 0; j < K_MAX; j++)
            begin
                end_v_reg[j] <= end_v_next[j];
                few_v_reg[j] <= few_v_next[j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            for (int j = 0; j < K_MAX; j++)
            begin
                end_reg[j] <= end_next[j];
                few_reg[j] <= few_next[j];
            end
        end
    end

    // read right after the step that produced it, before any clear applies
    assign sel_sum   = end_reg[sel_idx];
    assign sel_valid = end_v_reg[sel_idx];

endmodule

`default_nettype wire

// File: design/mskds_back.sv
`default_nettype none

module mskds_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire mskds_pkg::q_out_t q,
    output logic                   pop,
    input  wire mskds_pkg::sum_t   sel_sum,
    input  wire logic              sel_valid,
    output mskds_pkg::sum_t        max_sum,
    output logic                   found,
    output logic                   out_valid,
    input  wire logic              out_stall
);
    import mskds_pkg::*;

    logic b_valid_reg;
    logic b_valid_next;
    logic b_last_reg;
    logic b_last_next;
    sum_t ob_reg;
    sum_t ob_next;
    logic ob_v_reg;
    logic ob_v_next;
    logic out_valid_reg;
    logic out_valid_next;
    sum_t max_sum_reg;
    logic found_reg;

    logic go;
    logic consume;
    logic take;
    sum_t new_ob;
    logic new_ob_v;

    // only a final beat waits on a full output register
    assign go      = !(b_valid_reg && b_last_reg && out_valid_reg && out_stall);
    assign pop     = go && q.valid;
    assign consume = go && b_valid_reg;

    assign take     = sel_valid && (!ob_v_reg || sel_sum > ob_reg);
    assign new_ob   = take ? sel_sum : ob_reg;
    assign new_ob_v = take || ob_v_reg;

    always_comb
    begin
        b_valid_next   = b_valid_reg;
        b_last_next    = b_last_reg;
        ob_next        = ob_reg;
        ob_v_next      = ob_v_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (go)
        begin
            b_valid_next = pop;
            b_last_next  = q.item.last;
        end
        if (consume)
        begin
            if (b_last_reg)
            begin
                ob_next        = '0;
                ob_v_next      = 1'b0;
                out_valid_next = 1'b1;
            end
            else
            begin
                ob_next   = new_ob;
                ob_v_next = new_ob_v;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            b_last_reg    <= 1'b0;
            ob_reg        <= '0;
            ob_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg   <= b_valid_next;
            b_last_reg    <= b_last_next;
            ob_reg        <= ob_next;
            ob_v_reg      <= ob_v_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (consume && b_last_reg)
        begin
            max_sum_reg <= new_ob_v ? new_ob : '0;
            found_reg   <= new_ob_v;
        end
    end

    assign max_sum   = max_sum_reg;
    assign found     = found_reg;
    assign out_valid = out_valid_reg;

    a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !found_reg |-> max_sum_reg == '0)
        else $error("not-found result carries nonzero sum");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        consume && b_last_reg |=> !ob_v_reg && out_valid_reg)
        else $error("sequence end did not emit and clear");

    a_hold_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
        !go |-> !pop)
        else $error("queue popped while back end held");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q.valid)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

// File: verif/max_sum_k_disjoint_subarrays_tb.sv
`timescale 1ns / 1ps

module max_sum_k_disjoint_subarrays_tb;

    localparam int K_MAX       = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int ITEMS       = 1200;
    localparam int DRAIN_WAIT  = 8;
    localparam int LONG_HOLD   = 400;
    localparam int LIMIT       = 400000;

    localparam logic signed [VALUE_WIDTH-1:0] VAL_MAX = 32'sh7fff_ffff;
    localparam logic signed [VALUE_WIDTH-1:0] VAL_MIN = 32'sh8000_0000;
    localparam longint SUM_MAX = 64'sh7fff_ffff_ffff_ffff;
    localparam longint SUM_MIN = 64'sh8000_0000_0000_0000;

    typedef enum int {
        STYLE_FULL,
        STYLE_SMALL,
        STYLE_CORNER,
        STYLE_NEGATIVE
    } value_style_e;

    class best_runs_board;
        longint      end_sum[K_MAX];
        bit          end_ok[K_MAX];
        longint      fewer_sum[K_MAX];
        bit          fewer_ok[K_MAX];
        longint      best;
        bit          best_ok;
        int unsigned runs;
        longint      due_sum[$];
        bit          due_found[$];
        int          errors;

        function new();
            runs   = 1;
            errors = 0;
            clear();
        endfunction

        function void clear();
            for (int j = 0; j < K_MAX; j++)
            begin
                end_sum[j]   = 0;
                end_ok[j]    = 0;
                fewer_sum[j] = 0;
                fewer_ok[j]  = 0;
            end
            best    = 0;
            best_ok = 0;
        endfunction

        function longint sat_add(longint a, longint b);
            longint r;
            r = a + b;
            if (a[63] == b[63] && r[63] != a[63])
                r = a[63] ? SUM_MIN : SUM_MAX;
            return r;
        endfunction

        function void note_beat(logic signed [VALUE_WIDTH-1:0] v, bit is_last);
            longint x;
            longint f;
            longint b;
            bit     fo;
            bit     bo;
            int     kk;
            x  = longint'(v);
            kk = (runs == 0) ? 1 : (runs > K_MAX) ? K_MAX : runs;
            for (int j = K_MAX - 1; j >= 0; j--)
            begin
                if (j == 0)
                begin
                    f  = 0;
                    fo = 1;
                end
                else
                begin
                    f  = fewer_sum[j];
                    fo = fewer_ok[j];
                    if (end_ok[j-1] && (!fo || end_sum[j-1] > f))
                    begin
                        f  = end_sum[j-1];
                        fo = 1;
                    end
                end
                fewer_sum[j] = fo ? f : 0;
                fewer_ok[j]  = fo;
                b  = f;
                bo = fo;
                if (end_ok[j] && (!bo || end_sum[j] > b))
                begin
                    b  = end_sum[j];
                    bo = 1;
                end
                end_sum[j] = bo ? sat_add(b, x) : 0;
                end_ok[j]  = bo;
            end
            if (end_ok[kk-1] && (!best_ok || end_sum[kk-1] > best))
            begin
                best    = end_sum[kk-1];
                best_ok = 1;
            end
            if (is_last)
            begin
                due_sum.push_back(best_ok ? best : 0);
                due_found.push_back(best_ok);
                clear();
            end
        endfunction

        function void check_beat(logic signed [63:0] s, bit f);
            longint es;
            bit     ef;
            if (due_sum.size() == 0)
            begin
                $error("unexpected result: max_sum %0d found %0d", s, f);
                errors++;
                return;
            end
            es = due_sum.pop_front();
            ef = due_found.pop_front();
            if (f !== ef)
            begin
                $error("found mismatch: expected %0d, actual %0d", ef, f);
                errors++;
            end
            if (s !== es)
            begin
                $error("max_sum mismatch: expected %0d, actual %0d", es, s);
                errors++;
            end
        endfunction

        function int pending();
            return due_sum.size();
        endfunction
    endclass

    logic                                   clk;
    logic                                   rst_n;
    logic                                   in_valid;
    logic                                   in_stall;
    logic signed [VALUE_WIDTH-1:0]          value;
    logic                                   last;
    logic                                   out_valid;
    logic                                   out_stall;
    logic signed [mskds_pkg::SUM_W-1:0]     max_sum;
    logic                                   found;
    logic                                   cfg_valid;
    logic                                   cfg_ready;
    logic [mskds_pkg::CFG_W-1:0]            segment_count;

    best_runs_board board;
    int unsigned    cycles;
    int             sent;
    bit             tx_busy;
    bit             rx_busy;
    int             hold_req;
    logic signed [VALUE_WIDTH-1:0] seq_buf[$];

    max_sum_k_disjoint_subarrays #(
        .K_MAX       (K_MAX),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .value         (value),
        .last          (last),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .max_sum       (max_sum),
        .found         (found),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .segment_count (segment_count)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("FAIL max_sum_k_disjoint_subarrays");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
            board.runs = 32'(segment_count);
        if (rst_n && in_valid && !in_stall)
            board.note_beat(value, last);
        if (rst_n && out_valid && !out_stall)
            board.check_beat(max_sum, found);
    end

    // result side: per-beat stall draw, plus a long hold-off on request
    initial
    begin
        int stall_left;
        int hold_seen;
        stall_left = 0;
        hold_seen  = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req != hold_seen)
            begin
                hold_seen  = hold_req;
                stall_left = LONG_HOLD;
            end
            else if (out_valid && !out_stall)
                stall_left = rx_busy ? $urandom_range(0, 9) : 0;
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    function automatic logic signed [VALUE_WIDTH-1:0] pick_value(value_style_e style);
        case (style)
            STYLE_FULL:  return $urandom;
            STYLE_SMALL: return $signed($urandom_range(0, 400)) - 200;
            STYLE_CORNER:
            begin
                case ($urandom_range(0, 3))
                    0:       return VAL_MAX;
                    1:       return VAL_MIN;
                    2:       return -1;
                    default: return 0;
                endcase
            end
            default:     return -$signed($urandom_range(1, 1000));
        endcase
    endfunction

    task automatic send_item(logic signed [VALUE_WIDTH-1:0] v, bit l);
        int gap;
        gap = tx_busy ? $urandom_range(0, 9) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        last     <= l;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent++;
    endtask

    task automatic send_seq();
        for (int i = 0; i < seq_buf.size(); i++)
            send_item(seq_buf[i], i == seq_buf.size() - 1);
        seq_buf.delete();
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_runs(int k);
        drain();
        cfg_valid     <= 1'b1;
        segment_count <= k[mskds_pkg::CFG_W-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int k;
        int kk;
        int len;
        int nseq;
        int phase;
        value_style_e style;
        int corner_k[5];
        board     = new();
        cycles    = 0;
        sent      = 0;
        hold_req  = 0;
        tx_busy   = 1'b0;
        rx_busy   = 1'b0;
        corner_k  = '{1, 16, 31, 0, 17};
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        value         <= '0;
        last          <= 1'b0;
        out_stall     <= 1'b0;
        cfg_valid     <= 1'b0;
        segment_count <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // k = 1 after reset: single-beat sequences at the value extremes and zero, then a short mixed one
        seq_buf.push_back(VAL_MAX);
        send_seq();
        seq_buf.push_back(VAL_MIN);
        send_seq();
        seq_buf.push_back(0);
        send_seq();
        seq_buf.push_back(-5);
        seq_buf.push_back(3);
        seq_buf.push_back(-1);
        seq_buf.push_back(4);
        send_seq();

        write_runs(3);
        seq_buf.push_back(5);
        seq_buf.push_back(-1);
        send_seq();
        seq_buf.push_back(-7);
        seq_buf.push_back(-8);
        seq_buf.push_back(-9);
        seq_buf.push_back(-1);
        send_seq();

        // zero count behaves as one
        write_runs(0);
        seq_buf.push_back(3);
        seq_buf.push_back(-4);
        seq_buf.push_back(5);
        send_seq();

        // count above the cell count clamps to the top
        write_runs(31);
        seq_buf.push_back(VAL_MIN);
        seq_buf.push_back(VAL_MAX);
        seq_buf.push_back(VAL_MIN);
        send_seq();

        phase = 0;
        while (sent < ITEMS)
        begin
            if (phase < 5)
                k = corner_k[phase];
            else if ($urandom_range(0, 3) == 0)
                k = $urandom_range(0, 31);
            else
                k = $urandom_range(1, 16);
            write_runs(k);
            kk = (k == 0) ? 1 : (k > K_MAX) ? K_MAX : k;
            tx_busy = $urandom_range(0, 2) != 0;
            rx_busy = $urandom_range(0, 2) != 0;

            if (phase == 3)
            begin
                // hold the result side while short sequences pile up
                tx_busy = 1'b0;
                hold_req <= hold_req + 1;
                repeat (24)
                begin
                    seq_buf.push_back(pick_value(STYLE_FULL));
                    send_seq();
                end
            end

            nseq = $urandom_range(4, 12);
            repeat (nseq)
            begin
                if ($urandom_range(0, 5) == 0)
                    len = $urandom_range(1, kk);
                else
                    len = $urandom_range(1, 2 * kk + 8);
                style = value_style_e'($urandom_range(0, 3));
                repeat (len)
                    seq_buf.push_back(pick_value(style));
                send_seq();
            end
            phase++;
        end

        drain();
        if (board.errors == 0 && board.pending() == 0)
            $display("PASS max_sum_k_disjoint_subarrays");
        else
            $display("FAIL max_sum_k_disjoint_subarrays");
        $finish;
    end

endmodule
